// File: rtl/core/ltbe_pkg.sv
// ----------------------------------------------------------------------------
// ltbe_pkg
// Shared types and constants of the line text buffer editor: key codes,
// key classes, sequencer phases, cursor commands and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ltbe_pkg;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] PRINT_LOW    = 8'h20;
  localparam logic [7:0] PRINT_HIGH   = 8'h7D;
  localparam logic [7:0] KC_BACKSPACE = 8'h08;
  localparam logic [7:0] KC_ENTER     = 8'h0D;
  localparam logic [7:0] KC_UP        = 8'h80;
  localparam logic [7:0] KC_DOWN      = 8'h81;
  localparam logic [7:0] KC_LEFT      = 8'h82;
  localparam logic [7:0] KC_RIGHT     = 8'h83;
  localparam logic [7:0] KC_END       = 8'h84;
  localparam logic [7:0] KC_HOME      = 8'h85;

  localparam int BANNER_LEN = 7;
  localparam logic [7:0] BANNER [BANNER_LEN] = '{8'h3B, 8'h45, 8'h44, 8'h49, 8'h54, 8'h4F, 8'h52};

  typedef enum logic [3:0] {
    K_NONE  = 4'd0,
    K_READ  = 4'd1,
    K_PRINT = 4'd2,
    K_ENTER = 4'd3,
    K_BKSP  = 4'd4,
    K_UP    = 4'd5,
    K_DOWN  = 4'd6,
    K_LEFT  = 4'd7,
    K_RIGHT = 4'd8,
    K_END   = 4'd9,
    K_HOME  = 4'd10
  } kind_e;

  typedef enum logic [4:0] {
    P_INIT       = 5'd0,
    P_RDCELL     = 5'd1,
    P_INS_CHK    = 5'd2,
    P_INS_SHIFT  = 5'd3,
    P_INS_PUT    = 5'd4,
    P_ENT_CHK    = 5'd5,
    P_ENT_MOVE   = 5'd6,
    P_ENT_SPLIT  = 5'd7,
    P_ENT_PADN   = 5'd8,
    P_ENT_CLR    = 5'd9,
    P_BS_PREV    = 5'd10,
    P_BS_CUR     = 5'd11,
    P_BS_UP      = 5'd12,
    P_BS_LAST    = 5'd13,
    P_BS_FIND    = 5'd14,
    P_BS_CHK     = 5'd15,
    P_BS_DEL     = 5'd16,
    P_BS_CLRLAST = 5'd17
  } phase_e;

  typedef enum logic [3:0] {
    CUR_HOLD  = 4'd0,
    CUR_UP    = 4'd1,
    CUR_DOWN  = 4'd2,
    CUR_LEFT  = 4'd3,
    CUR_RIGHT = 4'd4,
    CUR_END   = 4'd5,
    CUR_HOME  = 4'd6,
    CUR_ENTER = 4'd7,
    CUR_FIX   = 4'd8
  } cur_e;

  typedef enum logic [1:0] {
    M_FILL = 2'd0,
    M_COPY = 2'd1,
    M_SCAN = 2'd2
  } mode_e;

  typedef struct packed {
    logic   accept;
    logic   start;
    phase_e phase;
    logic   from_cur;
    cur_e   cur;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic  busy;
    logic  any_ns;
    kind_e kind;
    logic  rd_ok;
    logic  row_zero;
    logic  row_last;
    logic  col_zero;
    logic  col_last;
    logic  out_busy;
  } status_t;

endpackage

// File: rtl/core/ltbe_in_if.sv
// ----------------------------------------------------------------------------
// ltbe_in_if
// Keystroke / read request channel with valid-ready handshake.
// ----------------------------------------------------------------------------
interface ltbe_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] key_code;
  logic [3:0] read_row;
  logic [4:0] read_column;

  modport source (output valid, action, key_code, read_row, read_column, input ready);
  modport sink (input valid, action, key_code, read_row, read_column, output ready);
endinterface

// File: rtl/core/ltbe_out_if.sv
// ----------------------------------------------------------------------------
// ltbe_out_if
// Result channel with valid-ready handshake.
// ----------------------------------------------------------------------------
interface ltbe_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cursor_row;
  logic [4:0] cursor_column;
  logic [3:0] window_top;
  logic [4:0] window_left;
  logic [1:0] screen_row;
  logic [4:0] screen_column;
  logic [7:0] cell_char;
  logic       refresh;

  modport source (output valid, cursor_row, cursor_column, window_top, window_left,
                  screen_row, screen_column, cell_char, refresh, input ready);
  modport sink (input valid, cursor_row, cursor_column, window_top, window_left,
                screen_row, screen_column, cell_char, refresh, output ready);
endinterface

// File: rtl/core/ltbe_ram.sv
// ----------------------------------------------------------------------------
// ltbe_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ltbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ltbe_datapath.sv
// ----------------------------------------------------------------------------
// ltbe_datapath
// Text grid memory with a block copy / fill / scan engine, cursor and
// window registers, and the result register.
// ----------------------------------------------------------------------------
module ltbe_datapath import ltbe_pkg::*; #(
  parameter int ROWS         = 16,
  parameter int COLUMNS      = 32,
  parameter int VIEW_ROWS    = 2,
  parameter int VIEW_COLUMNS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic       action_i,
  input  logic [7:0] key_code_i,
  input  logic [3:0] read_row_i,
  input  logic [4:0] read_column_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] cursor_row_o,
  output logic [4:0] cursor_column_o,
  output logic [3:0] window_top_o,
  output logic [4:0] window_left_o,
  output logic [1:0] screen_row_o,
  output logic [4:0] screen_column_o,
  output logic [7:0] cell_char_o,
  output logic       refresh_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;

  logic          act_q;
  logic [7:0]    key_q;
  logic [3:0]    rr_q;
  logic [4:0]    rc_q;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] vt_q, vt_d;
  logic [CW-1:0] vl_q, vl_d;

  logic          busy_q, rv_q;
  mode_e         mode_q, s_mode;
  logic          desc_q, s_desc;
  logic          init_q;
  logic [AW-1:0] src_q, dst_q, s_src, s_dst;
  logic [NW-1:0] cnt_q, s_cnt;
  logic [7:0]    fill_q, s_fill;
  logic          any_ns_q;
  logic [CW-1:0] idx_q, last_idx_q;
  logic [7:0]    cell_q;

  logic          issue;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [7:0]    init_char;

  logic          out_valid_q;
  logic [3:0]    o_row_q, o_vt_q;
  logic [4:0]    o_col_q, o_vl_q, o_scol_q;
  logic [1:0]    o_srow_q;
  logic [7:0]    o_cell_q;
  logic          o_refresh_q;

  kind_e         kind;

  // key classification
  always_comb begin
    kind = K_NONE;
    if (act_q) begin
      kind = K_READ;
    end else if (key_q >= PRINT_LOW && key_q <= PRINT_HIGH) begin
      kind = K_PRINT;
    end else begin
      case (key_q)
        KC_ENTER:     kind = K_ENTER;
        KC_BACKSPACE: kind = K_BKSP;
        KC_UP:        kind = K_UP;
        KC_DOWN:      kind = K_DOWN;
        KC_LEFT:      kind = K_LEFT;
        KC_RIGHT:     kind = K_RIGHT;
        KC_END:       kind = K_END;
        KC_HOME:      kind = K_HOME;
        default:      kind = K_NONE;
      endcase
    end
  end

  // block operation setup per phase
  always_comb begin
    int r, c, f;
    r      = int'(row_q);
    c      = int'(col_q);
    f      = cmd_i.from_cur ? r : r - 1;
    s_mode = M_SCAN;
    s_desc = 1'b0;
    s_src  = '0;
    s_dst  = '0;
    s_cnt  = '0;
    s_fill = SPACE_CHAR;
    case (cmd_i.phase)
      P_INIT: begin
        s_mode = M_FILL;
        s_cnt  = NW'(DEPTH);
      end
      P_RDCELL: begin
        s_src = AW'(int'(rr_q) * COLUMNS + int'(rc_q));
        s_cnt = NW'(1);
      end
      P_INS_CHK: begin
        s_src = AW'(r * COLUMNS + COLUMNS - 1);
        s_cnt = NW'(1);
      end
      P_INS_SHIFT: begin
        s_mode = M_COPY;
        s_desc = 1'b1;
        s_src  = AW'(r * COLUMNS + COLUMNS - 2);
        s_dst  = AW'(r * COLUMNS + COLUMNS - 1);
        s_cnt  = NW'(COLUMNS - 1 - c);
      end
      P_INS_PUT: begin
        s_mode = M_FILL;
        s_dst  = AW'(r * COLUMNS + c);
        s_cnt  = NW'(1);
        s_fill = key_q;
      end
      P_ENT_CHK: begin
        s_src = AW'((ROWS - 1) * COLUMNS);
        s_cnt = NW'(COLUMNS);
      end
      P_ENT_MOVE: begin
        s_mode = M_COPY;
        s_desc = 1'b1;
        s_src  = AW'((ROWS - 1) * COLUMNS - 1);
        s_dst  = AW'(DEPTH - 1);
        s_cnt  = NW'((ROWS - 1 - r) * COLUMNS);
      end
      P_ENT_SPLIT: begin
        s_mode = M_COPY;
        s_src  = AW'(r * COLUMNS + c);
        s_dst  = AW'((r + 1) * COLUMNS);
        s_cnt  = NW'(COLUMNS - c);
      end
      P_ENT_PADN: begin
        s_mode = M_FILL;
        s_dst  = AW'((r + 1) * COLUMNS + COLUMNS - c);
        s_cnt  = NW'(c);
      end
      P_ENT_CLR: begin
        s_mode = M_FILL;
        s_dst  = AW'(r * COLUMNS + c);
        s_cnt  = NW'(COLUMNS - c);
      end
      P_BS_PREV: begin
        s_src = AW'((r - 1) * COLUMNS);
        s_cnt = NW'(COLUMNS);
      end
      P_BS_CUR, P_BS_FIND: begin
        s_src = AW'(r * COLUMNS);
        s_cnt = NW'(COLUMNS);
      end
      P_BS_UP: begin
        s_mode = M_COPY;
        s_src  = AW'((f + 1) * COLUMNS);
        s_dst  = AW'(f * COLUMNS);
        s_cnt  = NW'((ROWS - 1 - f) * COLUMNS);
      end
      P_BS_LAST: begin
        s_mode = M_FILL;
        s_dst  = AW'((ROWS - 1) * COLUMNS);
        s_cnt  = NW'(COLUMNS);
      end
      P_BS_CHK: begin
        s_src = AW'(r * COLUMNS + c);
        s_cnt = NW'(1);
      end
      P_BS_DEL: begin
        s_mode = M_COPY;
        s_src  = AW'(r * COLUMNS + c + 1);
        s_dst  = AW'(r * COLUMNS + c);
        s_cnt  = NW'(COLUMNS - 1 - c);
      end
      P_BS_CLRLAST: begin
        s_mode = M_FILL;
        s_dst  = AW'(r * COLUMNS + COLUMNS - 1);
        s_cnt  = NW'(1);
      end
      default: begin
        s_mode = M_SCAN;
      end
    endcase
  end

  assign issue     = busy_q && (cnt_q != '0);
  assign init_char = (dst_q < AW'(BANNER_LEN)) ? BANNER[dst_q[2:0]] : SPACE_CHAR;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = ram_rdata;
    if (mode_q == M_FILL) begin
      ram_we    = issue;
      ram_wdata = init_q ? init_char : fill_q;
    end else begin
      ram_re = issue;
      ram_we = rv_q && (mode_q == M_COPY);
    end
  end

  ltbe_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (src_q),
    .rdata_o (ram_rdata)
  );

  // engine control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rv_q   <= 1'b0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      rv_q   <= 1'b0;
    end else begin
      rv_q <= issue && (mode_q != M_FILL);
      if (busy_q && (cnt_q == '0) && !rv_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  // engine pointers and scan results
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q   <= s_mode;
      desc_q   <= s_desc;
      init_q   <= (cmd_i.phase == P_INIT);
      src_q    <= s_src;
      dst_q    <= s_dst;
      cnt_q    <= s_cnt;
      fill_q   <= s_fill;
      any_ns_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (issue) begin
        cnt_q <= cnt_q - NW'(1);
        if (mode_q != M_FILL) begin
          src_q <= desc_q ? src_q - AW'(1) : src_q + AW'(1);
        end
      end
      if (ram_we) begin
        dst_q <= desc_q ? dst_q - AW'(1) : dst_q + AW'(1);
      end
      if (rv_q && mode_q == M_SCAN) begin
        cell_q <= ram_rdata;
        idx_q  <= idx_q + CW'(1);
        if (ram_rdata != SPACE_CHAR) begin
          any_ns_q   <= 1'b1;
          last_idx_q <= idx_q;
        end
      end
    end
    if (cmd_i.accept) begin
      cell_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= action_i;
      key_q <= key_code_i;
      rr_q  <= read_row_i;
      rc_q  <= read_column_i;
    end
  end

  // cursor
  always_comb begin
    logic [CW-1:0] c;
    c     = any_ns_q ? last_idx_q : col_q;
    row_d = row_q;
    col_d = col_q;
    case (cmd_i.cur)
      CUR_UP: begin
        if (row_q != '0) row_d = row_q - RW'(1);
      end
      CUR_DOWN: begin
        if (32'(row_q) < ROWS - 1) row_d = row_q + RW'(1);
      end
      CUR_LEFT: begin
        if (col_q != '0) col_d = col_q - CW'(1);
      end
      CUR_RIGHT: begin
        if (32'(col_q) < COLUMNS - 1) col_d = col_q + CW'(1);
      end
      CUR_END:  col_d = CW'(COLUMNS - 1);
      CUR_HOME: col_d = '0;
      CUR_ENTER: begin
        if (32'(row_q) < ROWS - 1) row_d = row_q + RW'(1);
        col_d = '0;
      end
      CUR_FIX: begin
        col_d = (32'(c) < COLUMNS - 1) ? c + CW'(1) : c;
      end
      default: begin
        row_d = row_q;
      end
    endcase
  end

  // window follows cursor
  always_comb begin
    logic [CW:0] dcol;
    logic [RW:0] drow;
    dcol = {1'b0, col_q} - {1'b0, vl_q};
    drow = {1'b0, row_q} - {1'b0, vt_q};
    vl_d = vl_q;
    vt_d = vt_q;
    if (col_q < vl_q) begin
      vl_d = col_q;
    end else if (32'(dcol) >= VIEW_COLUMNS) begin
      vl_d = CW'(32'(col_q) - VIEW_COLUMNS + 1);
    end
    if (row_q < vt_q) begin
      vt_d = row_q;
    end else if (32'(drow) >= VIEW_ROWS) begin
      vt_d = RW'(32'(row_q) - VIEW_ROWS + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      vt_q        <= '0;
      vl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (cmd_i.finish) begin
        vt_q        <= vt_d;
        vl_q        <= vl_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      o_row_q     <= 4'(row_q);
      o_col_q     <= 5'(col_q);
      o_vt_q      <= 4'(vt_d);
      o_vl_q      <= 5'(vl_d);
      o_srow_q    <= 2'(RW'(row_q - vt_d));
      o_scol_q    <= 5'(CW'(col_q - vl_d));
      o_cell_q    <= act_q ? cell_q : 8'h00;
      o_refresh_q <= !act_q && (key_q != 8'h00);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_row_o    = o_row_q;
  assign cursor_column_o = o_col_q;
  assign window_top_o    = o_vt_q;
  assign window_left_o   = o_vl_q;
  assign screen_row_o    = o_srow_q;
  assign screen_column_o = o_scol_q;
  assign cell_char_o     = o_cell_q;
  assign refresh_o       = o_refresh_q;

  always_comb begin
    status_o.busy     = busy_q;
    status_o.any_ns   = any_ns_q;
    status_o.kind     = kind;
    status_o.rd_ok    = (32'(rr_q) < ROWS) && (32'(rc_q) < COLUMNS);
    status_o.row_zero = (row_q == '0);
    status_o.row_last = (32'(row_q) == ROWS - 1);
    status_o.col_zero = (col_q == '0);
    status_o.col_last = (32'(col_q) == COLUMNS - 1);
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

endmodule

// File: rtl/core/ltbe_ctrl.sv
// ----------------------------------------------------------------------------
// ltbe_ctrl
// Controller: decodes each keystroke into a sequence of block operations
// and cursor updates, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ltbe_ctrl import ltbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_START  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   prev_ns_q, prev_ns_d;
  logic   from_cur_q, from_cur_d;
  cur_e   cur;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    prev_ns_d  = prev_ns_q;
    from_cur_d = from_cur_q;
    cur        = CUR_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (status_i.kind)
          K_READ: begin
            if (status_i.rd_ok) begin
              phase_d = P_RDCELL;
              state_d = S_START;
            end
          end
          K_PRINT: begin
            phase_d = P_INS_CHK;
            state_d = S_START;
          end
          K_ENTER: begin
            if (status_i.row_last) begin
              cur = CUR_ENTER;
            end else begin
              phase_d = P_ENT_CHK;
              state_d = S_START;
            end
          end
          K_BKSP: begin
            if (status_i.col_zero) begin
              if (!status_i.row_zero) begin
                phase_d = P_BS_PREV;
                state_d = S_START;
              end
            end else if (status_i.col_last) begin
              phase_d = P_BS_CHK;
              state_d = S_START;
            end else begin
              cur     = CUR_LEFT;
              phase_d = P_BS_DEL;
              state_d = S_START;
            end
          end
          K_UP:    cur = CUR_UP;
          K_DOWN:  cur = CUR_DOWN;
          K_LEFT:  cur = CUR_LEFT;
          K_RIGHT: cur = CUR_RIGHT;
          K_END:   cur = CUR_END;
          K_HOME:  cur = CUR_HOME;
          default: cur = CUR_HOLD;
        endcase
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!status_i.busy) begin
          state_d = S_START;
          case (phase_q)
            P_INIT:      state_d = S_IDLE;
            P_RDCELL:    state_d = S_FINISH;
            P_INS_CHK: begin
              if (status_i.any_ns) state_d = S_FINISH;
              else phase_d = P_INS_SHIFT;
            end
            P_INS_SHIFT: phase_d = P_INS_PUT;
            P_INS_PUT: begin
              cur     = CUR_RIGHT;
              state_d = S_FINISH;
            end
            P_ENT_CHK: begin
              if (status_i.any_ns) begin
                cur     = CUR_ENTER;
                state_d = S_FINISH;
              end else begin
                phase_d = P_ENT_MOVE;
              end
            end
            P_ENT_MOVE:  phase_d = P_ENT_SPLIT;
            P_ENT_SPLIT: phase_d = P_ENT_PADN;
            P_ENT_PADN:  phase_d = P_ENT_CLR;
            P_ENT_CLR: begin
              cur     = CUR_ENTER;
              state_d = S_FINISH;
            end
            P_BS_PREV: begin
              prev_ns_d = status_i.any_ns;
              phase_d   = P_BS_CUR;
            end
            P_BS_CUR: begin
              if (prev_ns_q && status_i.any_ns) begin
                cur     = CUR_UP;
                phase_d = P_BS_FIND;
              end else begin
                from_cur_d = !status_i.any_ns;
                phase_d    = P_BS_UP;
              end
            end
            P_BS_UP:     phase_d = P_BS_LAST;
            P_BS_LAST: begin
              cur     = CUR_UP;
              phase_d = P_BS_FIND;
            end
            P_BS_FIND: begin
              cur     = CUR_FIX;
              state_d = S_FINISH;
            end
            P_BS_CHK: begin
              if (status_i.any_ns) begin
                phase_d = P_BS_CLRLAST;
              end else begin
                cur     = CUR_LEFT;
                phase_d = P_BS_DEL;
              end
            end
            P_BS_DEL:     phase_d = P_BS_CLRLAST;
            P_BS_CLRLAST: state_d = S_FINISH;
            default:      state_d = S_FINISH;
          endcase
        end
      end
      S_FINISH: begin
        if (!status_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_START;
      phase_q    <= P_INIT;
      prev_ns_q  <= 1'b0;
      from_cur_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      prev_ns_q  <= prev_ns_d;
      from_cur_q <= from_cur_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.start    = (state_q == S_START);
    cmd_o.phase    = phase_q;
    cmd_o.from_cur = from_cur_q;
    cmd_o.cur      = cur;
    cmd_o.finish   = (state_q == S_FINISH) && !status_i.out_busy;
  end

endmodule

// File: rtl/core/line_text_buffer_editor_core.sv
// ----------------------------------------------------------------------------
// line_text_buffer_editor_core
// Text grid editor: one keystroke or one cell read per transfer, one result
// per transfer.
// ----------------------------------------------------------------------------
// After reset the grid memory is cleared to spaces with the banner on row 0,
// during which no keystroke is taken. Cursor keys and ignored codes need no
// grid access; reads and grid edits (insert, delete, enter and backspace
// joining lines) move or scan cells one at a time through the single grid
// memory. The next item is taken once the result is in the output register.
// ----------------------------------------------------------------------------
module line_text_buffer_editor_core import ltbe_pkg::*; #(
  parameter int ROWS         = 16,
  parameter int COLUMNS      = 32,
  parameter int VIEW_ROWS    = 2,
  parameter int VIEW_COLUMNS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltbe_in_if.sink    item_i,
  ltbe_out_if.source result_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign item_i.ready = in_ready;

  ltbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ltbe_datapath #(
    .ROWS         (ROWS),
    .COLUMNS      (COLUMNS),
    .VIEW_ROWS    (VIEW_ROWS),
    .VIEW_COLUMNS (VIEW_COLUMNS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (item_i.action),
    .key_code_i      (item_i.key_code),
    .read_row_i      (item_i.read_row),
    .read_column_i   (item_i.read_column),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .cursor_row_o    (result_o.cursor_row),
    .cursor_column_o (result_o.cursor_column),
    .window_top_o    (result_o.window_top),
    .window_left_o   (result_o.window_left),
    .screen_row_o    (result_o.screen_row),
    .screen_column_o (result_o.screen_column),
    .cell_char_o     (result_o.cell_char),
    .refresh_o       (result_o.refresh)
  );

endmodule
